@@ rtl/lcdq_pkg.sv @@
// Shared types, constants and the setup command table for the LCD nibble queue driver.
// No dependencies; used by lcdq_front, lcdq_back and the top level.
`default_nettype none

package lcdq_pkg;

  // Nibble queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_WAIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_WAIT     = 2'd2;

  // Register reset values
  localparam logic [7:0] POWER_UP_WAIT_RST = 8'd10;
  localparam logic [7:0] WAKE_WAIT_RST     = 8'd2;
  localparam logic [7:0] MODE_WAIT_RST     = 8'd1;

  // Wake sequence phases
  localparam logic [2:0] PHASE_POWER_UP  = 3'd0;
  localparam logic [2:0] PHASE_LAST_WAKE = 3'd2;
  localparam logic [2:0] PHASE_MODE_NIB  = 3'd3;
  localparam logic [2:0] PHASE_SETUP     = 3'd4;
  localparam logic [2:0] PHASE_READY     = 3'd5;

  // Raw wake nibbles
  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_MODE = 4'h2;

  // Setup commands queued at the end of the wake sequence
  localparam logic [7:0] SETUP_FUNC_SET = 8'h28;
  localparam logic [7:0] SETUP_DISP_OFF = 8'h08;
  localparam logic [7:0] SETUP_CLEAR    = 8'h01;
  localparam logic [7:0] SETUP_ENTRY    = 8'h06;
  localparam logic [7:0] SETUP_DISP_ON  = 8'h0C;
  localparam int SETUP_IDX_W = 4;
  localparam logic [SETUP_IDX_W-1:0] SETUP_LAST = 4'd9;

  // One queue entry: command tag and nibble
  typedef struct packed {
    logic       cmd;
    logic [3:0] nib;
  } lcdq_entry_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic        push;
    lcdq_entry_t hi;
    lcdq_entry_t lo;
  } lcdq_op_t;

  // Result beat
  typedef struct packed {
    logic       push_accepted;
    logic       strobe;
    logic [3:0] nibble;
    logic       reg_select;
    logic       ready;
  } lcdq_res_t;

  // Nibble k of the setup sequence, high nibble of each command first
  function automatic logic [3:0] setup_nibble(input logic [SETUP_IDX_W-1:0] k);
    logic [7:0] b;
    case (k[SETUP_IDX_W-1:1])
      3'd0:    b = SETUP_FUNC_SET;
      3'd1:    b = SETUP_DISP_OFF;
      3'd2:    b = SETUP_CLEAR;
      3'd3:    b = SETUP_ENTRY;
      default: b = SETUP_DISP_ON;
    endcase
    return k[0] ? b[3:0] : b[7:4];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lcdq_front.sv @@
// Front end: accepts items, splits a push byte into tagged nibbles, holds them in a
// two-entry op queue for the back end. Depends on lcdq_pkg.
`default_nettype none

module lcdq_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic             func,
  input  wire logic [7:0]       data_byte,
  input  wire logic             is_command,
  output logic                  op_valid,
  input  wire logic             op_ready,
  output lcdq_pkg::lcdq_op_t    op
);

  lcdq_pkg::lcdq_op_t in_op;
  lcdq_pkg::lcdq_op_t slot0;
  lcdq_pkg::lcdq_op_t slot1;
  logic [1:0] count;
  logic       wsel;
  logic       rsel;
  logic       accept;
  logic       pop;

  // Classify the incoming beat
  always_comb begin
    in_op.push   = func;
    in_op.hi.cmd = is_command;
    in_op.hi.nib = data_byte[7:4];
    in_op.lo.cmd = is_command;
    in_op.lo.nib = data_byte[3:0];
  end

  assign item_ready = (count != 2'd2);
  assign op_valid   = (count != 2'd0);
  assign op         = rsel ? slot1 : slot0;
  assign accept     = item_valid && item_ready;
  assign pop        = op_valid && op_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wsel) begin
        slot1 <= in_op;
      end else begin
        slot0 <= in_op;
      end
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wsel  <= 1'b0;
      rsel  <= 1'b0;
    end else begin
      if (accept) begin
        wsel <= ~wsel;
      end
      if (pop) begin
        rsel <= ~rsel;
      end
      if (accept && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !accept) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/lcdq_back.sv @@
// Back end: wake sequencer, nibble queue memory, delay counter, config registers and
// the result register. Depends on lcdq_pkg.
`default_nettype none

module lcdq_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               op_valid,
  output logic                                    op_ready,
  input  wire lcdq_pkg::lcdq_op_t                 op,
  input  wire logic                               cfg_write,
  input  wire logic [lcdq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output lcdq_pkg::lcdq_res_t                     res
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PUSH_LO = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;
  localparam logic [1:0] ST_SETUP   = 2'd3;

  logic [1:0]                       state;
  logic [lcdq_pkg::PTR_W-1:0]       wr_ptr;
  logic [lcdq_pkg::PTR_W-1:0]       rd_ptr;
  logic [lcdq_pkg::CNT_W-1:0]       fill;
  logic [7:0]                       wait_counter;
  logic [2:0]                       phase;
  logic [lcdq_pkg::SETUP_IDX_W-1:0] setup_idx;
  lcdq_pkg::lcdq_entry_t            lo_hold;
  logic [7:0]                       wake_wait;
  logic [7:0]                       mode_wait;

  lcdq_pkg::lcdq_entry_t mem [lcdq_pkg::QUEUE_DEPTH];
  lcdq_pkg::lcdq_entry_t mem_rdata;
  lcdq_pkg::lcdq_entry_t mem_wdata;
  logic                  mem_we;
  logic                  mem_re;

  logic start;
  logic is_ready;
  logic have_room;

  function automatic logic [lcdq_pkg::PTR_W-1:0] next_ptr(
    input logic [lcdq_pkg::PTR_W-1:0] p
  );
    return (p == lcdq_pkg::PTR_W'(lcdq_pkg::QUEUE_DEPTH - 1)) ?
           '0 : p + lcdq_pkg::PTR_W'(1);
  endfunction

  // Op start and queue status
  assign is_ready  = (phase >= lcdq_pkg::PHASE_READY);
  assign have_room = (fill <= lcdq_pkg::CNT_W'(lcdq_pkg::QUEUE_DEPTH - 2));
  assign start     = (state == ST_IDLE) && op_valid && (!res_valid || res_ready);
  assign op_ready  = start;

  // Memory port control: one write, one registered read
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = op.hi;
    case (state)
      ST_IDLE: begin
        mem_we = start && op.push && is_ready && have_room;
      end
      ST_PUSH_LO: begin
        mem_we    = 1'b1;
        mem_wdata = lo_hold;
      end
      ST_SETUP: begin
        mem_we        = 1'b1;
        mem_wdata.cmd = 1'b1;
        mem_wdata.nib = lcdq_pkg::setup_nibble(setup_idx);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = start && !op.push && is_ready && (fill != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[rd_ptr];
    end
  end

  // Push low nibble holding register
  always_ff @(posedge clk) begin
    if (start) begin
      lo_hold <= op.lo;
    end
  end

  // Sequencer, queue pointers, wake timing, config and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fill          <= '0;
      wait_counter  <= lcdq_pkg::POWER_UP_WAIT_RST;
      phase         <= lcdq_pkg::PHASE_POWER_UP;
      setup_idx     <= '0;
      wake_wait     <= lcdq_pkg::WAKE_WAIT_RST;
      mode_wait     <= lcdq_pkg::MODE_WAIT_RST;
      res_valid     <= 1'b0;
      res           <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            if (op.push) begin
              if (is_ready && have_room) begin
                wr_ptr <= next_ptr(wr_ptr);
                state  <= ST_PUSH_LO;
              end else begin
                res_valid <= 1'b1;
                res       <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b0, 4'h0, 1'b0, is_ready};
              end
            end else if (!is_ready) begin
              if (wait_counter != 8'd0) begin
                // still counting down
                wait_counter <= wait_counter - 8'd1;
                res_valid    <= 1'b1;
                res          <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b0, 4'h0, 1'b0, 1'b0};
              end else if (phase <= lcdq_pkg::PHASE_LAST_WAKE) begin
                wait_counter <= wake_wait;
                phase        <= phase + 3'd1;
                res_valid    <= 1'b1;
                res <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b1, lcdq_pkg::NIB_WAKE, 1'b0, 1'b0};
              end else if (phase == lcdq_pkg::PHASE_MODE_NIB) begin
                wait_counter <= mode_wait;
                phase        <= lcdq_pkg::PHASE_SETUP;
                res_valid    <= 1'b1;
                res <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b1, lcdq_pkg::NIB_MODE, 1'b0, 1'b0};
              end else begin
                // queue the setup commands, one nibble a cycle
                setup_idx <= '0;
                state     <= ST_SETUP;
              end
            end else if (fill != '0) begin
              rd_ptr <= next_ptr(rd_ptr);
              fill   <= fill - lcdq_pkg::CNT_W'(1);
              state  <= ST_READ;
            end else begin
              res_valid <= 1'b1;
              res       <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b0, 4'h0, 1'b0, 1'b1};
            end
          end
        end
        ST_PUSH_LO: begin
          wr_ptr    <= next_ptr(wr_ptr);
          fill      <= fill + lcdq_pkg::CNT_W'(2);
          state     <= ST_IDLE;
          res_valid <= 1'b1;
          res       <= lcdq_pkg::lcdq_res_t'{1'b1, 1'b0, 4'h0, 1'b0, 1'b1};
        end
        ST_READ: begin
          state     <= ST_IDLE;
          res_valid <= 1'b1;
          res <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b1, mem_rdata.nib, ~mem_rdata.cmd, 1'b1};
        end
        ST_SETUP: begin
          wr_ptr <= next_ptr(wr_ptr);
          fill   <= fill + lcdq_pkg::CNT_W'(1);
          if (setup_idx == lcdq_pkg::SETUP_LAST) begin
            phase     <= lcdq_pkg::PHASE_READY;
            state     <= ST_IDLE;
            res_valid <= 1'b1;
            res       <= lcdq_pkg::lcdq_res_t'{1'b0, 1'b0, 4'h0, 1'b0, 1'b1};
          end else begin
            setup_idx <= setup_idx + lcdq_pkg::SETUP_IDX_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Register writes; power-up delay reloads while still in the first wait
      if (cfg_write) begin
        case (cfg_index)
          lcdq_pkg::REG_POWER_UP_WAIT: begin
            if (phase == lcdq_pkg::PHASE_POWER_UP) begin
              wait_counter <= cfg_data;
            end
          end
          lcdq_pkg::REG_WAKE_WAIT: begin
            wake_wait <= cfg_data;
          end
          lcdq_pkg::REG_MODE_WAIT: begin
            mode_wait <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_queue_driver.sv @@
// Top level of the 4-bit character LCD driver: front end, op queue and back end.
// Depends on lcdq_pkg, lcdq_front and lcdq_back.
`default_nettype none

// Each item is one beat: func=0 is a timer tick, func=1 pushes a byte as two nibbles.
// Every item returns exactly one result beat. Items pass through a two-entry op queue
// and are then carried out one at a time by the back end: a tick that waits, sends a
// wake nibble or finds the queue empty, and a refused push, are answered from the idle
// state; an accepted push makes two writes through the single write port of the nibble
// memory; a tick that sends a queued nibble uses a registered memory read; the tick that
// ends the wake sequence holds the back end while the ten setup nibbles are written.
// The result register frees the back end as soon as a waiting result is taken.
// Configuration writes are taken in every cycle (cfg_ready is always high).
module char_lcd_nibble_queue_driver (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic                           func,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           is_command,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic                                push_accepted,
  output logic                                strobe_res,
  output logic [3:0]                          nibble,
  output logic                                reg_select,
  output logic                                ready_res,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lcdq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  lcdq_pkg::lcdq_op_t  op;
  lcdq_pkg::lcdq_res_t res;
  logic                op_valid;
  logic                op_ready;

  assign cfg_ready = 1'b1;

  lcdq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .func       (func),
    .data_byte  (data_byte),
    .is_command (is_command),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op)
  );

  lcdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (res)
  );

  // Result fields
  assign push_accepted = res.push_accepted;
  assign strobe_res    = res.strobe;
  assign nibble        = res.nibble;
  assign reg_select    = res.reg_select;
  assign ready_res     = res.ready;

endmodule

`default_nettype wire

@@ rtl/lcdq_checker.sv @@
// Port-level checker for the LCD nibble queue driver, bound to the top level.
// Watches the result channel only; no package dependency.
`default_nettype none

module lcdq_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic                           push_accepted,
  input wire logic                           strobe_res,
  input wire logic [3:0]                     nibble,
  input wire logic                           reg_select,
  input wire logic                           ready_res
);

  logic seen_ready;

  // Remembers that some result beat already reported the wake sequence done
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ready <= 1'b0;
    end else if (result_valid && result_ready && ready_res) begin
      seen_ready <= 1'b1;
    end
  end

  // Once ready, every later result stays ready
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_ready |-> ready_res)
    else $error("ready_res dropped after wake sequence finished");

  // No strobe: data lines and RS read as zero
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !strobe_res |-> (nibble == 4'h0) && !reg_select)
    else $error("nibble or reg_select nonzero without strobe");

  // A push result never carries a strobe
  a_push_no_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid && push_accepted |-> !strobe_res && ready_res)
    else $error("accepted push shows a strobe or not ready");

  // Character data only goes out once the display is set up
  a_data_after_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && strobe_res && reg_select |-> ready_res)
    else $error("data nibble sent before wake sequence finished");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(nibble)
      && $stable(strobe_res) && $stable(push_accepted))
    else $error("result changed while stalled");

endmodule

bind char_lcd_nibble_queue_driver lcdq_checker u_lcdq_checker (.*);

`default_nettype wire
